// File: rtl/gbn_pkg.sv
package gbn_pkg;

  localparam int unsigned MAX_PACKETS = 1024;

  localparam int unsigned BASE_W   = 11;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned ACK_W    = 16;
  localparam int unsigned ACTION_W = 3;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PACKETS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TIMEOUTS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_WINDOW   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_WINDOW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_WINDOW   = 3'd4;

  localparam logic [ACTION_W-1:0] ACT_START    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DATA_ACK = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CONN_ACK = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TIMEOUT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_OTHER    = 3'd4;

  localparam logic [BASE_W-1:0]  BASE_MAX  = 11'd2047;
  localparam logic [BASE_W-1:0]  BASE_INIT = 11'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    MODE_SLOW   = 2'd0,
    MODE_MEDIUM = 2'd1,
    MODE_FAST   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [BASE_W-1:0]  total_packets;
    logic [COUNT_W-1:0] max_timeouts;
    logic [BASE_W-1:0]  slow_window;
    logic [BASE_W-1:0]  medium_window;
    logic [BASE_W-1:0]  fast_window;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                checksum_ok;
    logic [ACK_W-1:0]    ack_number;
  } req_t;

  typedef struct packed {
    logic [BASE_W-1:0] send_number;
    logic              done_res;
    logic              failed;
    logic [BASE_W-1:0] cur_window;
    logic              duplicate_ack;
  } res_t;

endpackage

// File: rtl/gbn_if.sv
interface gbn_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        checksum_ok;
  logic [15:0] ack_number;

  modport source (output valid, output action, output checksum_ok, output ack_number,
                  input ready);
  modport sink   (input valid, input action, input checksum_ok, input ack_number,
                  output ready);
endinterface

interface gbn_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] send_number;
  logic        done_res;
  logic        failed;
  logic [10:0] cur_window;
  logic        duplicate_ack;

  modport source (output valid, output send_number, output done_res, output failed,
                  output cur_window, output duplicate_ack, input ready);
  modport sink   (input valid, input send_number, input done_res, input failed,
                  input cur_window, input duplicate_ack, output ready);
endinterface

// File: rtl/gbn_cfg_regs.sv
module gbn_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gbn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output gbn_pkg::cfg_t                  cfg
);
  import gbn_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_packets <= 11'd0;
      cfg_r.max_timeouts  <= 8'd5;
      cfg_r.slow_window   <= 11'd1;
      cfg_r.medium_window <= 11'd4;
      cfg_r.fast_window   <= 11'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL_PACKETS: cfg_r.total_packets <= cfg_wdata;
        REG_MAX_TIMEOUTS:  cfg_r.max_timeouts  <= cfg_wdata[COUNT_W-1:0];
        REG_SLOW_WINDOW:   cfg_r.slow_window   <= cfg_wdata;
        REG_MEDIUM_WINDOW: cfg_r.medium_window <= cfg_wdata;
        REG_FAST_WINDOW:   cfg_r.fast_window   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/gbn_core.sv
module gbn_core (
  input  logic          clk,
  input  logic          rst_n,
  input  gbn_pkg::cfg_t cfg,
  input  logic          fire,
  input  gbn_pkg::req_t req,
  output gbn_pkg::res_t res
);
  import gbn_pkg::*;

  logic [BASE_W-1:0]  base_r, base_nxt;
  mode_t              mode_r, mode_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [ACK_W-1:0]   base_ext;
  logic [ACK_W-1:0]   ack_diff;
  logic               ack_ahead;
  logic               ack_in_reach;
  logic               dup;
  logic               done;
  logic               fail;
  logic [BASE_W-1:0]  size;

  assign base_ext     = {{(ACK_W-BASE_W){1'b0}}, base_r};
  assign ack_diff     = req.ack_number - base_ext;
  assign ack_ahead    = req.ack_number > base_ext;
  assign ack_in_reach = ack_diff <= {{(ACK_W-BASE_W){1'b0}}, cfg.fast_window};

  always_comb begin
    base_nxt  = base_r;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    dup       = 1'b0;
    case (req.action)
      ACT_START: base_nxt = BASE_INIT;
      ACT_DATA_ACK: begin
        if (req.checksum_ok) begin
          count_nxt = '0;
          if (req.ack_number == base_ext) begin
            dup      = 1'b1;
            mode_nxt = MODE_SLOW;
          end else begin
            if (ack_ahead && ack_in_reach) begin
              base_nxt = (req.ack_number > {{(ACK_W-BASE_W){1'b0}}, BASE_MAX}) ?
                         BASE_MAX : req.ack_number[BASE_W-1:0];
            end
            case (mode_r)
              MODE_SLOW:   mode_nxt = MODE_MEDIUM;
              MODE_MEDIUM: mode_nxt = MODE_FAST;
              default:     mode_nxt = mode_r;
            endcase
          end
        end
      end
      ACT_CONN_ACK: begin
        if (req.checksum_ok) count_nxt = '0;
      end
      ACT_TIMEOUT: begin
        mode_nxt = MODE_SLOW;
        if (count_r != COUNT_MAX) count_nxt = count_r + 8'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mode_nxt)
      MODE_SLOW:   size = cfg.slow_window;
      MODE_MEDIUM: size = cfg.medium_window;
      default:     size = cfg.fast_window;
    endcase
  end

  assign done = base_nxt > cfg.total_packets;
  assign fail = !done && (count_nxt >= cfg.max_timeouts);

  always_comb begin
    res.send_number   = '0;
    if (!done && !fail && ({{(ACK_W-BASE_W){1'b0}}, base_nxt} <= ACK_W'(MAX_PACKETS))) begin
      res.send_number = base_nxt;
    end
    res.done_res      = done;
    res.failed        = fail;
    res.cur_window    = size;
    res.duplicate_ack = dup;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_INIT;
      mode_r  <= MODE_SLOW;
      count_r <= '0;
    end else if (fire) begin
      base_r  <= base_nxt;
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

  a_done_excludes_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.done_res && res.failed))
    else $error("done and failed reported together");

  a_start_resets_base: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.action == ACT_START |=> base_r == BASE_INIT)
    else $error("start request did not reset window base");

  a_timeout_slows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.action == ACT_TIMEOUT |=> mode_r == MODE_SLOW)
    else $error("timeout did not drop to slow mode");

  a_dup_source: assert property (@(posedge clk) disable iff (!rst_n)
    res.duplicate_ack |-> req.action == ACT_DATA_ACK && req.checksum_ok)
    else $error("duplicate flagged on a non data ack");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(base_r) && $stable(count_r))
    else $error("state changed without a request");

endmodule

// File: rtl/gbn_sender_ack_tracker.sv
// A request accepted on in_ch waits in the input register, then its result drives out_ch from
// the result register. Throughput: one request per cycle while out_ch is not stalled; the window
// base, mode and timeout count update as a request moves from the input to the result register.
// Reset: rst_n is synchronous, active low; it empties both pipeline registers,
// sets window base to 1, slow mode, timeout count 0 and the register defaults.
module gbn_sender_ack_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  gbn_in_if.sink                          in_ch,
  gbn_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gbn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gbn_pkg::*;

  cfg_t cfg;
  req_t req_r;
  logic req_valid_r;
  res_t res_nxt;
  res_t res_r;
  logic res_valid_r;
  logic out_free;
  logic fire;

  assign out_free    = !res_valid_r || out_ch.ready;
  assign fire        = req_valid_r && out_free;
  assign in_ch.ready = !req_valid_r || out_free;

  gbn_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gbn_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .req   (req_r),
    .res   (res_nxt)
  );

  // hold the request until the core takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r.action      <= in_ch.action;
      req_r.checksum_ok <= in_ch.checksum_ok;
      req_r.ack_number  <= in_ch.ack_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_free) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res_nxt;
  end

  assign out_ch.valid         = res_valid_r;
  assign out_ch.send_number   = res_r.send_number;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.failed        = res_r.failed;
  assign out_ch.cur_window    = res_r.cur_window;
  assign out_ch.duplicate_ack = res_r.duplicate_ack;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gbn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gbn_in_if in_ch ();
  gbn_out_if out_ch ();

  gbn_sender_ack_tracker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  cfg_t              win_cfg;
  logic [BASE_W-1:0] win_base;
  mode_t             win_mode;
  logic [COUNT_W-1:0] timeout_cnt;

  res_t pending_status[$];
  int   errors = 0;
  int   requests_sent = 0;
  int   results_seen = 0;
  int   settings_cnt = 0;
  int   cycle_cnt = 0;
  int   burst_left = 0;

  logic long_hold;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   stall_mode = 0;
  int   mode_left = 0;

  function automatic logic [BASE_W-1:0] mode_window();
    case (win_mode)
      MODE_SLOW:   return win_cfg.slow_window;
      MODE_MEDIUM: return win_cfg.medium_window;
      default:     return win_cfg.fast_window;
    endcase
  endfunction

  function automatic void tracker_reset();
    win_cfg.total_packets = '0;
    win_cfg.max_timeouts  = 8'd5;
    win_cfg.slow_window   = 11'd1;
    win_cfg.medium_window = 11'd4;
    win_cfg.fast_window   = 11'd8;
    win_base    = BASE_INIT;
    win_mode    = MODE_SLOW;
    timeout_cnt = '0;
  endfunction

  function automatic res_t track_event(logic [ACTION_W-1:0] act, logic ok,
                                       logic [ACK_W-1:0] ack);
    res_t r;
    int unsigned a;
    int unsigned b;
    logic dup;
    logic done;
    logic fail;
    a = ack;
    b = win_base;
    dup = 1'b0;
    if (act == ACT_START) begin
      win_base = BASE_INIT;
    end else if (act == ACT_DATA_ACK && ok) begin
      timeout_cnt = '0;
      if (a == b) begin
        dup = 1'b1;
        win_mode = MODE_SLOW;
      end else begin
        if (a > b && (a - b) <= win_cfg.fast_window)
          win_base = (a > BASE_MAX) ? BASE_MAX : a[BASE_W-1:0];
        if (win_mode == MODE_SLOW) win_mode = MODE_MEDIUM;
        else if (win_mode == MODE_MEDIUM) win_mode = MODE_FAST;
      end
    end else if (act == ACT_CONN_ACK && ok) begin
      timeout_cnt = '0;
    end else if (act == ACT_TIMEOUT) begin
      win_mode = MODE_SLOW;
      if (timeout_cnt < COUNT_MAX) timeout_cnt = timeout_cnt + 1'b1;
    end
    done = win_base > win_cfg.total_packets;
    fail = !done && timeout_cnt >= win_cfg.max_timeouts;
    r.send_number   = (!done && !fail && win_base <= MAX_PACKETS) ? win_base : '0;
    r.done_res      = done;
    r.failed        = fail;
    r.cur_window    = mode_window();
    r.duplicate_ack = dup;
    return r;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ERROR %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected result: expected none got send_number %0d",
                 $time, out_ch.send_number);
      end else begin
        want = pending_status.pop_front();
        report_field("send_number", want.send_number, out_ch.send_number);
        report_field("done_res", want.done_res, out_ch.done_res);
        report_field("failed", want.failed, out_ch.failed);
        report_field("cur_window", want.cur_window, out_ch.cur_window);
        report_field("duplicate_ack", want.duplicate_ack, out_ch.duplicate_ack);
      end
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (long_hold && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      if (!long_hold) begin
        hold_done <= 1'b0;
        hold_cnt = 0;
      end
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_status.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(logic [ACTION_W-1:0] act, logic ok, logic [ACK_W-1:0] ack);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.checksum_ok <= ok;
    in_ch.ack_number  <= ack;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_status.push_back(track_event(act, ok, ack));
    requests_sent++;
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TOTAL_PACKETS: win_cfg.total_packets = val;
      REG_MAX_TIMEOUTS:  win_cfg.max_timeouts  = val[COUNT_W-1:0];
      REG_SLOW_WINDOW:   win_cfg.slow_window   = val;
      REG_MEDIUM_WINDOW: win_cfg.medium_window = val;
      REG_FAST_WINDOW:   win_cfg.fast_window   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int total, int maxt, int slow, int med, int fast);
    drain();
    cfg_write(REG_TOTAL_PACKETS, CFG_DATA_W'(total));
    cfg_write(REG_MAX_TIMEOUTS, CFG_DATA_W'(maxt));
    cfg_write(REG_SLOW_WINDOW, CFG_DATA_W'(slow));
    cfg_write(REG_MEDIUM_WINDOW, CFG_DATA_W'(med));
    cfg_write(REG_FAST_WINDOW, CFG_DATA_W'(fast));
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    settings_cnt++;
  endtask

  task automatic test_reset_defaults();
    send_request(ACT_OTHER, 1'b0, 16'd0);
    send_request(ACT_DATA_ACK, 1'b1, 16'd1);
    send_request(ACT_DATA_ACK, 1'b1, 16'd9);
    send_request(ACT_DATA_ACK, 1'b1, 16'd8);
    send_request(ACT_TIMEOUT, 1'b0, 16'hFFFF);
    send_request(ACT_START, 1'b1, 16'd0);
  endtask

  task automatic test_window_rules();
    set_config(10, 3, 1, 4, 8);
    cfg_write(REG_UNUSED, 11'h7FF);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_request(ACT_START, 1'b0, 16'd0);
    send_request(ACT_DATA_ACK, 1'b1, 16'd1);
    send_request(ACT_DATA_ACK, 1'b1, 16'd2);
    send_request(ACT_DATA_ACK, 1'b0, 16'd3);
    send_request(ACT_DATA_ACK, 1'b1, 16'd0);
    send_request(ACT_DATA_ACK, 1'b1, 16'd11);
    send_request(ACT_DATA_ACK, 1'b1, 16'd10);
    send_request(ACT_CONN_ACK, 1'b0, 16'd0);
    repeat (3) send_request(ACT_TIMEOUT, 1'b1, 16'd0);
    send_request(ACT_OTHER, 1'b1, 16'd10);
    send_request(ACT_CONN_ACK, 1'b1, 16'hFFFF);
    send_request(3'd5, 1'b1, 16'd10);
    send_request(3'd6, 1'b0, 16'h5555);
    send_request(3'd7, 1'b1, 16'hAAAA);
    send_request(ACT_OTHER, 1'b0, 16'd10);
    send_request(ACT_TIMEOUT, 1'b1, 16'hFFFF);
    send_request(ACT_DATA_ACK, 1'b1, 16'd11);
    send_request(ACT_DATA_ACK, 1'b1, 16'hFFFF);
    send_request(ACT_START, 1'b1, 16'd0);
  endtask

  task automatic test_base_saturation();
    set_config(1024, 255, 1, 2, 1024);
    send_request(ACT_START, 1'b1, 16'd7);
    send_request(ACT_DATA_ACK, 1'b1, 16'd1025);
    send_request(ACT_DATA_ACK, 1'b1, 16'd2049);
    send_request(ACT_DATA_ACK, 1'b1, 16'd2047);
    send_request(ACT_DATA_ACK, 1'b1, 16'd3071);
    send_request(ACT_DATA_ACK, 1'b1, 16'd1024);
    send_request(ACT_START, 1'b0, 16'd0);
    send_request(ACT_DATA_ACK, 1'b1, 16'd1024);
    send_request(ACT_DATA_ACK, 1'b1, 16'd2048);
  endtask

  task automatic test_timeout_saturation();
    set_config(100, 255, 2, 3, 5);
    send_request(ACT_START, 1'b1, 16'd0);
    repeat (258) send_request(ACT_TIMEOUT, 1'($urandom_range(0, 1)), ACK_W'($urandom));
    send_request(ACT_CONN_ACK, 1'b1, 16'd0);
  endtask

  task automatic test_backpressure();
    set_config(60, 4, 1, 4, 8);
    long_hold <= 1'b1;
    burst_left = 1000;
    repeat (40) send_request(ACT_DATA_ACK, 1'b1, ACK_W'(win_base + $urandom_range(0, 3)));
    while (!hold_done) @(posedge clk);
    long_hold <= 1'b0;
    burst_left = 0;
  endtask

  task automatic run_sequence(int n);
    logic [ACTION_W-1:0] act;
    logic ok;
    int ackv;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      ok = ($urandom_range(0, 9) != 0);
      ackv = $urandom_range(0, 65535);
      if (win_base > win_cfg.total_packets && $urandom_range(0, 2) == 0) begin
        act = ACT_START;
      end else if (r < 8) begin
        act = ACTION_W'($urandom_range(0, 7));
        ok = 1'($urandom_range(0, 1));
      end else if (r < 12) begin
        act = ACT_START;
      end else if (r < 20) begin
        act = ACT_TIMEOUT;
      end else if (r < 25) begin
        act = ACT_CONN_ACK;
      end else if (r < 30) begin
        act = ACTION_W'($urandom_range(4, 7));
      end else begin
        act = ACT_DATA_ACK;
        r = $urandom_range(0, 99);
        if (r < 15) ackv = int'(win_base);
        else if (r < 25) ackv = int'(win_base) - $urandom_range(1, 4);
        else if (r < 35) ackv = win_base + win_cfg.fast_window + $urandom_range(1, 20);
        else ackv = win_base + $urandom_range(1, win_cfg.fast_window);
        if (ackv < 0) ackv = 0;
      end
      send_request(act, ok, ackv[ACK_W-1:0]);
    end
  endtask

  task automatic test_random_phases();
    set_config(40, 3, 1, 4, 8);
    run_sequence(125);
    set_config(1024, 255, 1024, 1024, 1024);
    run_sequence(125);
    set_config(0, 1, 1, 1, 1);
    run_sequence(125);
    set_config(1024, 1, 1, 2, 1024);
    run_sequence(125);
    set_config(200, 7, 3, 16, 32);
    run_sequence(125);
    repeat (3) begin
      set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 60),
                 ($urandom_range(0, 1) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 16),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 16),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 16));
      run_sequence(125);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_OTHER;
    in_ch.checksum_ok = 1'b0;
    in_ch.ack_number  = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_TOTAL_PACKETS;
    cfg_wdata         = '0;
    long_hold         = 1'b0;
    tracker_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_window_rules();
    test_base_saturation();
    test_timeout_saturation();
    test_backpressure();
    test_random_phases();

    drain();
    repeat (10) @(posedge clk);
    $display("Run covered %0d requests and %0d results over %0d register settings,",
             requests_sent, results_seen, settings_cnt);
    $display("with window rules, saturation, a long result hold-off and random traffic.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gbn_pkg.sv
rtl/gbn_if.sv
rtl/gbn_cfg_regs.sv
rtl/gbn_core.sv
rtl/gbn_sender_ack_tracker.sv
tb/tb_top.sv
